/* hw/rtl/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants of the sphere/frustum classifier: register
// indexes, register file layout, fixed-point constants and result codes.
// ----------------------------------------------------------------------------
package sfc_pkg;

	// register file write port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_POSITION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_AXIS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UP_AXIS         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_AXIS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF_FOV    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ASPECT_RATIO    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPHERE_FACTOR   = 3'd6;

	// field widths
	localparam int CAM_FIELD_W = 20;
	localparam int CAM_W       = 3 * CAM_FIELD_W;
	localparam int AXIS_W      = 16;
	localparam int AXIS_REG_W  = 3 * AXIS_W;
	localparam int FACTOR_W    = 16;
	localparam int SCALE_W     = 16;

	// sqrt2 in Q1.30, rounded to nearest
	localparam int SQRT2_W = 31;
	localparam logic [SQRT2_W-1:0] SQRT2_Q30 = 31'd1518500250;

	// radius: factor * scale * sqrt2, 42 fraction bits
	localparam int SR_W = FACTOR_W + SCALE_W + SQRT2_W;

	// reset values
	localparam logic [CAM_W-1:0]      CAMERA_RST = '0;
	localparam logic [AXIS_REG_W-1:0] RIGHT_RST  = 48'h0000_0000_4000;
	localparam logic [AXIS_REG_W-1:0] UP_RST     = 48'h0000_4000_0000;
	localparam logic [AXIS_REG_W-1:0] VIEW_RST   = 48'h4000_0000_0000;
	localparam logic [FACTOR_W-1:0]   TAN_RST    = 16'd4096;
	localparam logic [FACTOR_W-1:0]   ASPECT_RST = 16'd4096;
	localparam logic [FACTOR_W-1:0]   SPHERE_RST = 16'd5793;

	// containment codes
	localparam int CONT_W = 2;
	localparam logic [CONT_W-1:0] CONT_OUTSIDE   = 2'd0;
	localparam logic [CONT_W-1:0] CONT_INTERSECT = 2'd1;
	localparam logic [CONT_W-1:0] CONT_INSIDE    = 2'd2;

	// register file contents
	typedef struct packed {
		logic [CAM_W-1:0]      camera_position;
		logic [AXIS_REG_W-1:0] right_axis;
		logic [AXIS_REG_W-1:0] up_axis;
		logic [AXIS_REG_W-1:0] view_axis;
		logic [FACTOR_W-1:0]   tan_half_fov;
		logic [FACTOR_W-1:0]   aspect_ratio;
		logic [FACTOR_W-1:0]   sphere_factor;
	} cfg_t;

endpackage

/* hw/rtl/sfc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sfc_cfg_regs
// Camera and frustum register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sfc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfc_pkg::CFG_DATA_W-1:0] cfg_data,
	output sfc_pkg::cfg_t                  cfg
);
	import sfc_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_position <= CAMERA_RST;
			cfg_q.right_axis      <= RIGHT_RST;
			cfg_q.up_axis         <= UP_RST;
			cfg_q.view_axis       <= VIEW_RST;
			cfg_q.tan_half_fov    <= TAN_RST;
			cfg_q.aspect_ratio    <= ASPECT_RST;
			cfg_q.sphere_factor   <= SPHERE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAMERA_POSITION: cfg_q.camera_position <= cfg_data[CAM_W-1:0];
				REG_RIGHT_AXIS:      cfg_q.right_axis      <= cfg_data[AXIS_REG_W-1:0];
				REG_UP_AXIS:         cfg_q.up_axis         <= cfg_data[AXIS_REG_W-1:0];
				REG_VIEW_AXIS:       cfg_q.view_axis       <= cfg_data[AXIS_REG_W-1:0];
				REG_TAN_HALF_FOV:    cfg_q.tan_half_fov    <= cfg_data[FACTOR_W-1:0];
				REG_ASPECT_RATIO:    cfg_q.aspect_ratio    <= cfg_data[FACTOR_W-1:0];
				REG_SPHERE_FACTOR:   cfg_q.sphere_factor   <= cfg_data[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/sfc_project.sv */
// ----------------------------------------------------------------------------
// sfc_project
// Stages 1 to 3: offset from the camera, per-axis products, dot product sums
// and the widened sphere radius.
// ----------------------------------------------------------------------------
module sfc_project #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  sfc_pkg::cfg_t                          cfg,
	input  logic                                   in_valid,
	input  logic signed [COORD_WIDTH-1:0]          point_x,
	input  logic signed [COORD_WIDTH-1:0]          point_y,
	input  logic signed [COORD_WIDTH-1:0]          point_z,
	input  logic [sfc_pkg::SCALE_W-1:0]            cube_scale,
	output logic                                   out_valid,
	output logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+18:0] ax,
	output logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+18:0] ay,
	output logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+18:0] az,
	output logic [sfc_pkg::SR_W-1:0]               sr
);
	import sfc_pkg::*;

	// offset width, product width, dot sum width
	localparam int DW = (COORD_WIDTH > CAM_FIELD_W ? COORD_WIDTH : CAM_FIELD_W) + 1;
	localparam int PW = DW + AXIS_W;
	localparam int AW = PW + 2;
	localparam int FS_W = FACTOR_W + SCALE_W;

	logic signed [COORD_WIDTH-1:0] pt [3];
	logic signed [DW-1:0]          pt_ext [3];
	logic signed [DW-1:0]          cam_ext [3];
	logic [CAM_FIELD_W-1:0]        cam [3];
	logic [AXIS_REG_W-1:0]         axis_reg [3];
	logic signed [AXIS_W-1:0]      axc [3][3];

	logic                 valid_s1, valid_s2, valid_s3;
	logic signed [DW-1:0] v_s1 [3];
	logic [FS_W-1:0]      fs_s1;
	logic signed [PW-1:0] prod_s2 [3][3];
	logic [SR_W-1:0]      sr_s2, sr_s3;
	logic signed [AW-1:0] dot_s3 [3];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;
	assign axis_reg[0] = cfg.right_axis;
	assign axis_reg[1] = cfg.up_axis;
	assign axis_reg[2] = cfg.view_axis;

	// sign extension of point and camera fields to a common width
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cam[k]     = cfg.camera_position[CAM_FIELD_W*k +: CAM_FIELD_W];
			pt_ext[k]  = {{(DW-COORD_WIDTH){pt[k][COORD_WIDTH-1]}}, pt[k]};
			cam_ext[k] = {{(DW-CAM_FIELD_W){cam[k][CAM_FIELD_W-1]}}, cam[k]};
		end
	end

	// axis components
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 3; k++) begin
				axc[a][k] = axis_reg[a][AXIS_W*k +: AXIS_W];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: offset and factor times scale
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				v_s1[k] <= pt_ext[k] - cam_ext[k];
			end
			fs_s1 <= FS_W'(cfg.sphere_factor) * FS_W'(cube_scale);
		end
	end

	// stage 2: nine products and the radius
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[a][k] <= v_s1[k] * axc[a][k];
				end
			end
			sr_s2 <= SR_W'(fs_s1) * SR_W'(SQRT2_Q30);
		end
	end

	// stage 3: dot product sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				dot_s3[a] <= prod_s2[a][0] + prod_s2[a][1] + prod_s2[a][2];
			end
			sr_s3 <= sr_s2;
		end
	end

	assign out_valid = valid_s3;
	assign ax = dot_s3[0];
	assign ay = dot_s3[1];
	assign az = dot_s3[2];
	assign sr = sr_s3;

endmodule

/* hw/rtl/sfc_limits.sv */
// ----------------------------------------------------------------------------
// sfc_limits
// Stages 4 to 6: frustum half-extents at the item's depth and the band
// limits widened and narrowed by the radius, all at 42 fraction bits.
// ----------------------------------------------------------------------------
module sfc_limits #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  sfc_pkg::cfg_t                          cfg,
	input  logic                                   in_valid,
	input  logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+18:0] ax,
	input  logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+18:0] ay,
	input  logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+18:0] az,
	input  logic [sfc_pkg::SR_W-1:0]               sr,
	output logic                                   out_valid,
	output logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] wax,
	output logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] way,
	output logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] hi_x,
	output logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] lo_x,
	output logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] hi_y,
	output logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] lo_y
);
	import sfc_pkg::*;

	// offset width, dot width, depth times tan width, compare width
	localparam int DW  = (COORD_WIDTH > CAM_FIELD_W ? COORD_WIDTH : CAM_FIELD_W) + 1;
	localparam int AW  = DW + AXIS_W + 2;
	localparam int ZW  = AW + FACTOR_W;
	localparam int CMW = ZW + FACTOR_W + 2;

	logic signed [FACTOR_W:0] tan_s;
	logic signed [FACTOR_W:0] asp_s;
	logic signed [CMW-1:0]    limy_w;
	logic signed [CMW-1:0]    wax_w;
	logic signed [CMW-1:0]    way_w;
	logic signed [CMW-1:0]    sr_w;

	logic                  valid_s4, valid_s5, valid_s6;
	logic signed [ZW-1:0]  azt_s4;
	logic signed [AW-1:0]  ax_s4, ay_s4;
	logic [SR_W-1:0]       sr_s4;
	logic signed [CMW-1:0] limx_s5, limy_s5, wax_s5, way_s5, sr_s5;
	logic signed [CMW-1:0] wax_s6, way_s6, hix_s6, lox_s6, hiy_s6, loy_s6;

	assign tan_s = {1'b0, cfg.tan_half_fov};
	assign asp_s = {1'b0, cfg.aspect_ratio};

	// alignment to 42 fraction bits
	assign limy_w = {{(CMW-ZW-12){azt_s4[ZW-1]}}, azt_s4, 12'b0};
	assign wax_w  = {{(CMW-AW-24){ax_s4[AW-1]}}, ax_s4, 24'b0};
	assign way_w  = {{(CMW-AW-24){ay_s4[AW-1]}}, ay_s4, 24'b0};
	assign sr_w   = {{(CMW-SR_W){1'b0}}, sr_s4};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// stage 4: depth times tan of half fov
	always_ff @(posedge clk) begin
		if (en) begin
			azt_s4 <= az * tan_s;
			ax_s4  <= ax;
			ay_s4  <= ay;
			sr_s4  <= sr;
		end
	end

	// stage 5: horizontal extent and aligned operands
	always_ff @(posedge clk) begin
		if (en) begin
			limx_s5 <= azt_s4 * asp_s;
			limy_s5 <= limy_w;
			wax_s5  <= wax_w;
			way_s5  <= way_w;
			sr_s5   <= sr_w;
		end
	end

	// stage 6: limits widened and narrowed by the radius
	always_ff @(posedge clk) begin
		if (en) begin
			hix_s6 <= limx_s5 + sr_s5;
			lox_s6 <= limx_s5 - sr_s5;
			hiy_s6 <= limy_s5 + sr_s5;
			loy_s6 <= limy_s5 - sr_s5;
			wax_s6 <= wax_s5;
			way_s6 <= way_s5;
		end
	end

	assign out_valid = valid_s6;
	assign wax  = wax_s6;
	assign way  = way_s6;
	assign hi_x = hix_s6;
	assign lo_x = lox_s6;
	assign hi_y = hiy_s6;
	assign lo_y = loy_s6;

endmodule

/* hw/rtl/sfc_classify.sv */
// ----------------------------------------------------------------------------
// sfc_classify
// Stage 7: band tests on both axes and the output register of the block.
// ----------------------------------------------------------------------------
module sfc_classify #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] wax,
	input  logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] way,
	input  logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] hi_x,
	input  logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] lo_x,
	input  logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] hi_y,
	input  logic signed [COORD_WIDTH+(COORD_WIDTH>20?0:20-COORD_WIDTH)+52:0] lo_y,
	output logic                                   out_valid,
	output logic [sfc_pkg::CONT_W-1:0]             containment,
	output logic                                   visible
);
	import sfc_pkg::*;

	logic              outside_x, outside_y, touch_x, touch_y;
	logic [CONT_W-1:0] cls;

	logic              valid_s7;
	logic [CONT_W-1:0] cls_s7;
	logic              vis_s7;

	// outside the widened band, or reaching past the narrowed one
	always_comb begin
		outside_x = (wax > hi_x) || ((-hi_x) > wax);
		outside_y = (way > hi_y) || ((-hi_y) > way);
		touch_x   = (wax > lo_x) || ((-lo_x) > wax);
		touch_y   = (way > lo_y) || ((-lo_y) > way);
		if (outside_x || outside_y) begin
			cls = CONT_OUTSIDE;
		end else if (touch_x || touch_y) begin
			cls = CONT_INTERSECT;
		end else begin
			cls = CONT_INSIDE;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (en) begin
			cls_s7 <= cls;
			vis_s7 <= (cls != CONT_OUTSIDE);
		end
	end

	assign out_valid   = valid_s7;
	assign containment = cls_s7;
	assign visible     = vis_s7;

endmodule

/* hw/rtl/sphere_frustum_classify_top.sv */
// ----------------------------------------------------------------------------
// sphere_frustum_classify_top
// Classifies cubes against a view frustum by the radar method.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one cube per item: centre x, y, z (signed, four fraction
//    bits) and the integer cube scale. m_axis returns one result per item:
//    containment (outside, intersecting, inside) and a visible flag.
//  - Camera and frustum registers are written through cfg_we / cfg_index /
//    cfg_data, one register per cycle; the user must write them only while
//    no item is in flight, as the block itself does not enforce it.
//  - Throughput is one item per cycle unless the output stalls; the
//    seven-stage pipeline (offset, products, dot sums, depth scaling,
//    extents, limits, band tests) takes a new item every cycle it advances.
//  - When m_axis_tready is low with a result waiting, the whole pipeline
//    holds and s_axis_tready drops; nothing is lost or repeated.
//  - Reset clears all stage valid bits and loads the default camera: at the
//    origin, looking along +z, 90 degree vertical field, aspect 1.
// ----------------------------------------------------------------------------
module sphere_frustum_classify_top #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	// point_x, point_y, point_z, cube_scale, zero fill
	input  logic [((3*COORD_WIDTH+sfc_pkg::SCALE_W+7)/8)*8-1:0] s_axis_tdata,
	input  logic                                         s_axis_tvalid,
	output logic                                         s_axis_tready,
	// containment, visible, zero fill
	output logic [7:0]                                   m_axis_tdata,
	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	input  logic                                         cfg_we,
	input  logic [sfc_pkg::CFG_IDX_W-1:0]                cfg_index,
	input  logic [sfc_pkg::CFG_DATA_W-1:0]               cfg_data
);
	import sfc_pkg::*;

	localparam int DW  = (COORD_WIDTH > CAM_FIELD_W ? COORD_WIDTH : CAM_FIELD_W) + 1;
	localparam int AW  = DW + AXIS_W + 2;
	localparam int CMW = AW + 2 * FACTOR_W + 2;

	cfg_t cfg;
	logic en;

	logic signed [COORD_WIDTH-1:0] point_x, point_y, point_z;
	logic [SCALE_W-1:0]            cube_scale;

	logic                  prj_valid;
	logic signed [AW-1:0]  ax, ay, az;
	logic [SR_W-1:0]       sr;

	logic                  lim_valid;
	logic signed [CMW-1:0] wax, way, hi_x, lo_x, hi_y, lo_y;

	logic                  out_valid;
	logic [CONT_W-1:0]     containment;
	logic                  visible;

	// pipeline advances unless a result is held
	assign en            = !out_valid || m_axis_tready;
	assign s_axis_tready = en;

	// input item fields
	assign point_x    = s_axis_tdata[COORD_WIDTH-1:0];
	assign point_y    = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign point_z    = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
	assign cube_scale = s_axis_tdata[3*COORD_WIDTH +: SCALE_W];

	sfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfc_project #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_project (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.cube_scale (cube_scale),
		.out_valid  (prj_valid),
		.ax         (ax),
		.ay         (ay),
		.az         (az),
		.sr         (sr)
	);

	sfc_limits #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_limits (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.in_valid  (prj_valid),
		.ax        (ax),
		.ay        (ay),
		.az        (az),
		.sr        (sr),
		.out_valid (lim_valid),
		.wax       (wax),
		.way       (way),
		.hi_x      (hi_x),
		.lo_x      (lo_x),
		.hi_y      (hi_y),
		.lo_y      (lo_y)
	);

	sfc_classify #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (lim_valid),
		.wax         (wax),
		.way         (way),
		.hi_x        (hi_x),
		.lo_x        (lo_x),
		.hi_y        (hi_y),
		.lo_y        (lo_y),
		.out_valid   (out_valid),
		.containment (containment),
		.visible     (visible)
	);

	// result item
	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = {5'b0, visible, containment};

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// sphere_frustum_classify_top testbench
// Streams cubes through the frustum classifier and compares every result
// against a cycle-free predictor of the radar test. It keeps its own copy of
// the camera and frustum registers and rewrites them between phases while
// the pipeline is empty. Phases: directed corner cases under the reset
// camera, then random cubes under rotated, extreme, degenerate and random
// frustums, with random idling on both stream sides for rotated and extreme.
// ----------------------------------------------------------------------------
module testbench;
	import sfc_pkg::*;

	localparam int COORD_W = 20;
	localparam int TDATA_W = ((3 * COORD_W + SCALE_W + 7) / 8) * 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int Q1_14_ONE = 16384;
	localparam int Q1_14_HALF_SQRT2 = 11585;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [SCALE_W-1:0]        scale;
	} cube_t;

	typedef struct packed {
		logic [CONT_W-1:0] containment;
		logic              visible;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [TDATA_W-1:0]   s_axis_tdata = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copy used by the predictor
	cfg_t frustum_regs = '{
		camera_position: CAMERA_RST, right_axis: RIGHT_RST, up_axis: UP_RST,
		view_axis: VIEW_RST, tan_half_fov: TAN_RST, aspect_ratio: ASPECT_RST,
		sphere_factor: SPHERE_RST
	};

	verdict_t pending_verdicts[$];
	int       mismatch_count = 0;
	int       src_idle_pct = 0;
	int       dst_idle_pct = 0;

	sphere_frustum_classify_top #(
		.COORD_WIDTH(COORD_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// radar test: project the offset on the camera axes, compare with extents
	function automatic verdict_t classify_cube(cube_t c);
		logic signed [COORD_W:0] offs [3];
		logic signed [AXIS_W-1:0] rgt [3];
		logic signed [AXIS_W-1:0] upv [3];
		logic signed [AXIS_W-1:0] dir [3];
		logic signed [63:0] ax, ay, az;
		logic [SR_W-1:0] rad_u;
		logic signed [127:0] rad, wax, way, azt, lim_x, lim_y, tan_w, asp_w;
		verdict_t v;
		offs[0] = c.x - $signed(frustum_regs.camera_position[0 +: CAM_FIELD_W]);
		offs[1] = c.y - $signed(frustum_regs.camera_position[CAM_FIELD_W +: CAM_FIELD_W]);
		offs[2] = c.z - $signed(frustum_regs.camera_position[2*CAM_FIELD_W +: CAM_FIELD_W]);
		for (int k = 0; k < 3; k++) begin
			rgt[k] = frustum_regs.right_axis[AXIS_W*k +: AXIS_W];
			upv[k] = frustum_regs.up_axis[AXIS_W*k +: AXIS_W];
			dir[k] = frustum_regs.view_axis[AXIS_W*k +: AXIS_W];
		end
		ax = offs[0] * rgt[0] + offs[1] * rgt[1] + offs[2] * rgt[2];
		ay = offs[0] * upv[0] + offs[1] * upv[1] + offs[2] * upv[2];
		az = offs[0] * dir[0] + offs[1] * dir[1] + offs[2] * dir[2];
		// radius at 42 fraction bits
		rad_u = frustum_regs.sphere_factor * c.scale * SQRT2_Q30;
		rad = $signed({{(128-SR_W){1'b0}}, rad_u});
		wax = ax;
		wax = wax <<< 24;
		way = ay;
		way = way <<< 24;
		tan_w = $signed({112'd0, frustum_regs.tan_half_fov});
		asp_w = $signed({112'd0, frustum_regs.aspect_ratio});
		azt = az;
		azt = azt * tan_w;
		lim_y = azt <<< 12;
		lim_x = azt * asp_w;
		if (way > lim_y + rad || -(lim_y + rad) > way ||
				wax > lim_x + rad || -(lim_x + rad) > wax) begin
			v.containment = CONT_OUTSIDE;
		end else if (way > lim_y - rad || rad - lim_y > way ||
				wax > lim_x - rad || rad - lim_x > wax) begin
			// negative side reads ax < -maxX + sr
			v.containment = CONT_INTERSECT;
		end else begin
			v.containment = CONT_INSIDE;
		end
		v.visible = (v.containment != CONT_OUTSIDE);
		return v;
	endfunction

	function automatic cube_t make_cube(int x, int y, int z, int s);
		cube_t c;
		c.x = COORD_W'(x);
		c.y = COORD_W'(y);
		c.z = COORD_W'(z);
		c.scale = SCALE_W'(s);
		return c;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pack_camera(int x, int y, int z);
		logic [CAM_FIELD_W-1:0] fx, fy, fz;
		fx = CAM_FIELD_W'(x);
		fy = CAM_FIELD_W'(y);
		fz = CAM_FIELD_W'(z);
		return CFG_DATA_W'({fz, fy, fx});
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pack_axis(int x, int y, int z);
		logic [AXIS_W-1:0] fx, fy, fz;
		fx = AXIS_W'(x);
		fy = AXIS_W'(y);
		fz = AXIS_W'(z);
		return {{(CFG_DATA_W-AXIS_REG_W){1'b0}}, fz, fy, fx};
	endfunction

	task automatic report_mismatch(string what, int exp_val, int got_val);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch %s: expected %0d, got %0d", $time, what, exp_val, got_val);
	endtask

	// compare one result item with the oldest pending verdict
	task automatic check_result(logic [7:0] data);
		verdict_t want;
		if (pending_verdicts.size() == 0) begin
			report_mismatch("result with no item pending", 0, data);
		end else begin
			want = pending_verdicts.pop_front();
			if (data[CONT_W-1:0] !== want.containment)
				report_mismatch("containment", want.containment, data[CONT_W-1:0]);
			if (data[CONT_W] !== want.visible)
				report_mismatch("visible", want.visible, data[CONT_W]);
		end
	endtask

	// result side: check accepted items, stall at random
	always @(posedge clk) begin
		if (m_axis_tvalid === 1'b1 && m_axis_tready)
			check_result(m_axis_tdata);
		m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
	end

	// one register write, enable is lowered by the caller
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_CAMERA_POSITION: frustum_regs.camera_position = val[CAM_W-1:0];
			REG_RIGHT_AXIS:      frustum_regs.right_axis = val[AXIS_REG_W-1:0];
			REG_UP_AXIS:         frustum_regs.up_axis = val[AXIS_REG_W-1:0];
			REG_VIEW_AXIS:       frustum_regs.view_axis = val[AXIS_REG_W-1:0];
			REG_TAN_HALF_FOV:    frustum_regs.tan_half_fov = val[FACTOR_W-1:0];
			REG_ASPECT_RATIO:    frustum_regs.aspect_ratio = val[FACTOR_W-1:0];
			REG_SPHERE_FACTOR:   frustum_regs.sphere_factor = val[FACTOR_W-1:0];
			default: ;
		endcase
	endtask

	// full register load, plus a write to the unused index that must be ignored
	task automatic load_frustum(logic [CFG_DATA_W-1:0] cam, logic [CFG_DATA_W-1:0] rgt,
			logic [CFG_DATA_W-1:0] upv, logic [CFG_DATA_W-1:0] dir,
			logic [CFG_DATA_W-1:0] tan_v, logic [CFG_DATA_W-1:0] asp,
			logic [CFG_DATA_W-1:0] sph);
		write_reg(REG_CAMERA_POSITION, cam);
		write_reg(REG_RIGHT_AXIS, rgt);
		write_reg(REG_UP_AXIS, upv);
		write_reg(REG_VIEW_AXIS, dir);
		write_reg(REG_TAN_HALF_FOV, tan_v);
		write_reg(REG_ASPECT_RATIO, asp);
		write_reg(REG_SPHERE_FACTOR, sph);
		write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
		cfg_we <= 1'b0;
	endtask

	// offer one cube, idle at random first, return once it is accepted
	task automatic send_cube(cube_t c);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(TDATA_W-3*COORD_W-SCALE_W){1'b0}}, c.scale, c.z, c.y, c.x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_verdicts.push_back(classify_cube(c));
	endtask

	// hold the sender until every pending result is back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// random cube: mostly near the origin or the frustum sides, some raw noise
	function automatic cube_t random_cube();
		cube_t c;
		int mode, z, side;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			c.x = COORD_W'($urandom);
			c.y = COORD_W'($urandom);
			c.z = COORD_W'($urandom);
			c.scale = SCALE_W'($urandom);
		end else if (mode < 5) begin
			c.x = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			c.y = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			c.z = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			c.scale = SCALE_W'($urandom_range(0, 63));
		end else begin
			z = $urandom_range(16, 200000);
			side = $urandom_range(0, 1) ? z : -z;
			if ($urandom_range(0, 1)) begin
				c.x = COORD_W'(side + int'($urandom_range(0, 4095)) - 2048);
				c.y = COORD_W'(int'($urandom_range(0, 2 * z)) - z);
			end else begin
				c.x = COORD_W'(int'($urandom_range(0, 2 * z)) - z);
				c.y = COORD_W'(side + int'($urandom_range(0, 4095)) - 2048);
			end
			c.z = COORD_W'(z);
			c.x = c.x + $signed(frustum_regs.camera_position[0 +: CAM_FIELD_W]);
			c.y = c.y + $signed(frustum_regs.camera_position[CAM_FIELD_W +: CAM_FIELD_W]);
			c.z = c.z + $signed(frustum_regs.camera_position[2*CAM_FIELD_W +: CAM_FIELD_W]);
			c.scale = SCALE_W'($urandom_range(0, 255));
		end
		return c;
	endfunction

	// random stream with one full pause halfway
	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain_results();
			send_cube(random_cube());
		end
		drain_results();
	endtask

	// corner cases under the reset camera: sides, edges, behind, field extremes
	task automatic test_directed();
		src_idle_pct = 0;
		dst_idle_pct = 0;
		send_cube(make_cube(0, 0, 1600, 0));
		send_cube(make_cube(0, 0, 1600, 5));
		send_cube(make_cube(1500, 0, 1600, 10));
		send_cube(make_cube(-1500, 0, 1600, 10));
		send_cube(make_cube(0, 1500, 1600, 10));
		send_cube(make_cube(0, -1500, 1600, 10));
		send_cube(make_cube(2000, 0, 1600, 1));
		send_cube(make_cube(-2000, 0, 1600, 1));
		send_cube(make_cube(0, 2000, 1600, 1));
		send_cube(make_cube(0, -2000, 1600, 1));
		send_cube(make_cube(0, 0, -1600, 0));
		send_cube(make_cube(0, 0, -1600, 200));
		send_cube(make_cube(0, 0, 0, 0));
		send_cube(make_cube(0, 0, 0, 1));
		send_cube(make_cube(1600, 1600, 1600, 0));
		send_cube(make_cube(-1600, -1600, 1600, 0));
		send_cube(make_cube(-524288, -524288, -524288, 65535));
		send_cube(make_cube(524287, 524287, 524287, 65535));
		send_cube(make_cube(524287, -524288, 524287, 0));
		send_cube(make_cube(-524288, 524287, -524288, 0));
		send_cube(make_cube(0, 0, 524287, 65535));
		send_cube(make_cube(0, 0, 524287, 1));
		drain_results();
	endtask

	// camera moved and turned 45 degrees about y, narrow wide-screen view
	task automatic test_rotated_camera();
		load_frustum(pack_camera(1000, -2000, 500),
			pack_axis(Q1_14_HALF_SQRT2, 0, -Q1_14_HALF_SQRT2),
			pack_axis(0, Q1_14_ONE, 0),
			pack_axis(Q1_14_HALF_SQRT2, 0, Q1_14_HALF_SQRT2),
			2365, 7282, 6000);
		src_idle_pct = 35;
		dst_idle_pct = 63;
		run_random(420);
	endtask

	// every register at an extreme value
	task automatic test_extreme_frustum();
		load_frustum(pack_camera(-524288, 524287, 0),
			pack_axis(-32768, 32767, -32768),
			pack_axis(32767, -32768, 32767),
			pack_axis(0, -32768, 32767),
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		src_idle_pct = 63;
		dst_idle_pct = 35;
		run_random(420);
	endtask

	// zero field of view, zero aspect, zero widening, default axes
	task automatic test_degenerate_frustum();
		load_frustum(pack_camera(-1, -1, -1),
			pack_axis(Q1_14_ONE, 0, 0), pack_axis(0, Q1_14_ONE, 0),
			pack_axis(0, 0, Q1_14_ONE), 0, 0, 0);
		src_idle_pct = 0;
		dst_idle_pct = 0;
		run_random(200);
	endtask

	// random register contents, upper data bits included
	task automatic test_random_frustum();
		src_idle_pct = 0;
		dst_idle_pct = 0;
		for (int n = 0; n < 4; n++) begin
			load_frustum(CFG_DATA_W'({$urandom, $urandom}),
				CFG_DATA_W'({$urandom, $urandom}),
				CFG_DATA_W'({$urandom, $urandom}),
				CFG_DATA_W'({$urandom, $urandom}),
				CFG_DATA_W'({$urandom, $urandom}),
				CFG_DATA_W'({$urandom, $urandom}),
				CFG_DATA_W'({$urandom, $urandom}));
			run_random(60);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_rotated_camera();
		test_extreme_frustum();
		test_degenerate_frustum();
		test_random_frustum();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
			$display("[sphere_frustum_classify_top] OK");
		end else begin
			$display("[sphere_frustum_classify_top] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("[sphere_frustum_classify_top] ERROR");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_cfg_regs.sv
hw/rtl/sfc_project.sv
hw/rtl/sfc_limits.sv
hw/rtl/sfc_classify.sv
hw/rtl/sphere_frustum_classify_top.sv
bench/testbench.sv
